// ===== rtl/trm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants for the register machine execute unit.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PcW   = 11;

  // largest program the fetch side can hold
  localparam logic [PcW-1:0] ProgDepth = 11'd1024;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_JMP   = 3'd3,
    OP_PRINT = 3'd4,
    OP_MUL   = 3'd5,
    OP_DIV   = 3'd6,
    OP_JZ    = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_END  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_JUMP = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/trm_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_regfile
// Register file memory, one write and one registered read per cycle.
// Per-entry valid bits make unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module trm_regfile #(
  parameter int unsigned REG_COUNT = 16,
  parameter int unsigned RW        = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [RW-1:0]             rd_addr_i,
  output logic [trm_pkg::DataW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [RW-1:0]             wr_addr_i,
  input  logic [trm_pkg::DataW-1:0] wr_data_i
);

  logic [trm_pkg::DataW-1:0] mem_q [REG_COUNT];
  logic [REG_COUNT-1:0]      valid_q;
  logic [trm_pkg::DataW-1:0] rd_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/trm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_div
// Iterative signed divider, one quotient bit per cycle, truncating
// toward zero. The most negative value over minus one wraps.
// ----------------------------------------------------------------------------
module trm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  trm_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [trm_pkg::DataW-1:0] quot_o
);

  localparam int unsigned W  = trm_pkg::DataW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, quo_q, dsr_q;
  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    trial;

  assign mag_a = req_i.dividend[W-1] ? (W'(0) - req_i.dividend) : req_i.dividend;
  assign mag_b = req_i.divisor[W-1]  ? (W'(0) - req_i.divisor)  : req_i.divisor;
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dsr_q <= mag_b;
      neg_q <= req_i.dividend[W-1] ^ req_i.divisor[W-1];
    end else if (busy_q) begin
      rem_q <= trial[W] ? {rem_q[W-2:0], quo_q[W-1]} : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ~trial[W]};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/tiny_register_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_register_machine_execute_unit
// Execute stage of a small register machine with pc and halt status.
// ----------------------------------------------------------------------------
// One instruction word is taken at a time; the input stalls until the result
// word has been loaded into the output register. An accepted word goes
// through S_EXEC and then S_RESP, where its result word is loaded, and the
// next word can be taken once the unit is back in S_IDLE. A DIV that runs
// the divider also waits in S_DIV for the one-bit-per-cycle divider.
// A result waiting in the output register does not block the next accept;
// a stalled result only holds the following result back.
module tiny_register_machine_execute_unit #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [trm_pkg::PcW-1:0]     cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  func_i,
  input  logic [3:0]                  reg_index_i,
  input  logic signed [31:0]          immediate_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [trm_pkg::PcW-1:0]     next_pc_o,
  output logic [1:0]                  run_status_o,
  output logic                        print_valid_o,
  output logic signed [31:0]          print_value_o
);

  localparam int unsigned RW = $clog2(REG_COUNT);
  localparam int unsigned W  = trm_pkg::DataW;
  localparam int unsigned PW = trm_pkg::PcW;

  trm_pkg::state_e  state_q, state_d;
  trm_pkg::status_e status_q, status_d;
  trm_pkg::func_e   func_q;
  logic [PW-1:0]    pc_q, pc_d, len_q, pc_inc;
  logic [RW-1:0]    idx_q, idx_map, rd_addr;
  logic [W-1:0]     imm_q, rd_data, wr_data, div_quot, mul_lo;
  logic             wr_en, div_done, in_accept, resp_load, jump_ok;
  logic             prt_v_q, prt_v_d, out_valid_q;
  logic [W-1:0]     prt_q, prt_d;
  trm_pkg::div_req_t div_req;

  assign in_stall_o = (state_q != trm_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign resp_load  = (state_q == trm_pkg::S_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    idx_map = '0;
    for (int i = 0; i < 16; i++) begin
      if (reg_index_i == 4'(i)) begin
        idx_map = RW'(i % REG_COUNT);
      end
    end
  end

  assign rd_addr = (state_q == trm_pkg::S_IDLE) ? idx_map : idx_q;

  trm_regfile #(
    .REG_COUNT(REG_COUNT),
    .RW       (RW)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(idx_q),
    .wr_data_i(wr_data)
  );

  trm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .done_o(div_done),
    .quot_o(div_quot)
  );

  assign mul_lo  = W'(rd_data * imm_q);
  assign pc_inc  = pc_q + PW'(1);
  assign jump_ok = !imm_q[W-1] && (imm_q != '0) && (imm_q <= W'(len_q));

  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    pc_d             = pc_q;
    wr_en            = 1'b0;
    wr_data          = rd_data;
    prt_v_d          = prt_v_q;
    prt_d            = prt_q;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = imm_q;
    unique case (state_q)
      trm_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = trm_pkg::S_EXEC;
        end
      end
      trm_pkg::S_EXEC: begin
        state_d = trm_pkg::S_RESP;
        prt_v_d = 1'b0;
        prt_d   = '0;
        if (status_q != trm_pkg::ST_RUN) begin
          status_d = status_q;
        end else if (pc_q >= len_q) begin
          status_d = trm_pkg::ST_END;
        end else begin
          pc_d = pc_inc;
          unique case (func_q)
            trm_pkg::OP_SET: begin
              wr_en   = 1'b1;
              wr_data = imm_q;
            end
            trm_pkg::OP_ADD: begin
              wr_en   = 1'b1;
              wr_data = rd_data + imm_q;
            end
            trm_pkg::OP_SUB: begin
              wr_en   = 1'b1;
              wr_data = rd_data - imm_q;
            end
            trm_pkg::OP_MUL: begin
              wr_en   = 1'b1;
              wr_data = mul_lo;
            end
            trm_pkg::OP_DIV: begin
              if (imm_q == '0) begin
                status_d = trm_pkg::ST_DIV0;
              end else begin
                div_req.start = 1'b1;
                state_d       = trm_pkg::S_DIV;
              end
            end
            trm_pkg::OP_JMP: begin
              if (jump_ok) begin
                pc_d = imm_q[PW-1:0] - PW'(1);
              end else begin
                status_d = trm_pkg::ST_JUMP;
              end
            end
            trm_pkg::OP_JZ: begin
              if (rd_data == '0) begin
                if (jump_ok) begin
                  pc_d = imm_q[PW-1:0] - PW'(1);
                end else begin
                  status_d = trm_pkg::ST_JUMP;
                end
              end
            end
            trm_pkg::OP_PRINT: begin
              prt_v_d = 1'b1;
              prt_d   = rd_data;
            end
            default: begin
              pc_d = pc_inc;
            end
          endcase
          if (status_d == trm_pkg::ST_RUN && pc_d >= len_q) begin
            status_d = trm_pkg::ST_END;
          end
        end
      end
      trm_pkg::S_DIV: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_data = div_quot;
          state_d = trm_pkg::S_RESP;
        end
      end
      trm_pkg::S_RESP: begin
        if (resp_load) begin
          state_d = trm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = trm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trm_pkg::S_IDLE;
      status_q    <= trm_pkg::ST_RUN;
      pc_q        <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      prt_v_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pc_q     <= pc_d;
      prt_v_q  <= prt_v_d;
      if (cfg_we_i) begin
        len_q <= (cfg_wdata_i > trm_pkg::ProgDepth) ? trm_pkg::ProgDepth : cfg_wdata_i;
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prt_q <= prt_d;
    if (in_accept) begin
      func_q <= trm_pkg::func_e'(func_i);
      idx_q  <= idx_map;
      imm_q  <= immediate_i;
    end
    if (resp_load) begin
      next_pc_o     <= pc_q;
      run_status_o  <= status_q;
      print_valid_o <= prt_v_q;
      print_value_o <= prt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a halted machine stays halted until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != trm_pkg::ST_RUN) |=> (status_q != trm_pkg::ST_RUN))
    else $error("halt status cleared");

  a_pc_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trm_pkg::S_IDLE) |=> $stable(pc_q))
    else $error("pc moved without an instruction");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == trm_pkg::S_DIV))
    else $error("divider finished outside divide wait");

  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == trm_pkg::S_EXEC || state_q == trm_pkg::S_DIV))
    else $error("register write outside execute");

endmodule
